@@ sv/chd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_pkg: shared types and constants of the cartridge header decoder
// Holds the channel payloads, the job record passed from front to back,
// result codes and the TNES mapper translation.
// ----------------------------------------------------------------------------
package chd_pkg;

  // Header geometry.
  localparam int HEADER_LENGTH = 16;
  localparam int POS_BITS      = $clog2(HEADER_LENGTH);
  localparam logic [POS_BITS-1:0] POS_LAST = POS_BITS'(HEADER_LENGTH - 1);

  // Magic signatures.
  localparam logic [7:0] CH_N   = 8'h4E;
  localparam logic [7:0] CH_E   = 8'h45;
  localparam logic [7:0] CH_S   = 8'h53;
  localparam logic [7:0] CH_T   = 8'h54;
  localparam logic [7:0] CH_EOF = 8'h1A;

  // Flag byte fields.
  localparam logic [7:0] NES2_MASK  = 8'h0C;
  localparam logic [7:0] NES2_VALUE = 8'h08;
  localparam logic [3:0] EXP_FORM   = 4'hF;

  // Size units, as shift amounts: 16 KiB, 8 KiB and 8 KiB.
  localparam logic [3:0] PRG_UNIT_SHIFT  = 4'd14;
  localparam logic [3:0] CHR_UNIT_SHIFT  = 4'd13;
  localparam logic [3:0] TNES_UNIT_SHIFT = 4'd13;

  // Offsets.
  localparam logic [9:0] HEADER_BYTES  = 10'd16;
  localparam logic [9:0] TRAINER_BYTES = 10'd512;

  // TNES special values.
  localparam logic [7:0] TNES_FDS        = 8'd100;
  localparam logic [7:0] TNES_MAPPER_MAX = 8'd8;

  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_MAGIC  = 3'd1,
    ST_FDS        = 3'd2,
    ST_MAPPER     = 3'd3,
    ST_PRG_ZERO   = 3'd4,
    ST_PRG_OVER   = 3'd5,
    ST_CHR_OVER   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    FMT_INES = 2'd0,
    FMT_NES2 = 2'd1,
    FMT_TNES = 2'd2
  } fmt_t;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [31:0] image_size;
  } in_t;

  typedef struct packed {
    status_t     status;
    fmt_t        image_format;
    logic [11:0] mapper_number;
    logic [47:0] prg_bytes;
    logic [47:0] chr_bytes;
    logic [9:0]  trainer_bytes;
    logic [9:0]  prg_start;
    logic [48:0] chr_start;
  } out_t;

  // One classified header, ready for size decoding and range checks.
  typedef struct packed {
    status_t     pre_status;
    fmt_t        fmt;
    logic [11:0] mapper;
    logic        prg_exp;
    logic [11:0] prg_code;
    logic [3:0]  prg_shift;
    logic        chr_exp;
    logic [11:0] chr_code;
    logic [3:0]  chr_shift;
    logic        trainer;
    logic [31:0] image_size;
  } job_t;

  // TNES mapper numbers to their iNES equivalents.
  function automatic logic [11:0] tnes_mapper(input logic [7:0] code);
    logic [11:0] m;
    unique case (code)
      8'd0:    m = 12'd0;
      8'd1:    m = 12'd1;
      8'd2:    m = 12'd9;
      8'd3:    m = 12'd4;
      8'd4:    m = 12'd10;
      8'd5:    m = 12'd5;
      8'd6:    m = 12'd2;
      8'd7:    m = 12'd3;
      8'd8:    m = 12'd7;
      default: m = 12'd0;
    endcase
    return m;
  endfunction

endpackage

@@ sv/chd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_front: header byte capture and classification
// Collects header bytes, and with the last byte recognizes the format and
// pushes one job record into the queue.
// ----------------------------------------------------------------------------
module chd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  chd_pkg::in_t  in_data,
  output logic          q_push,
  output chd_pkg::job_t q_wdata,
  input  logic          q_full
);

  logic [chd_pkg::POS_BITS-1:0] pos_r, pos_nxt;
  logic [7:0] hdr_r [chd_pkg::HEADER_LENGTH-1];
  logic       last_byte;
  logic       accept;
  logic       is_ines, is_tnes, nes2;
  logic [3:0] prg_msb, chr_msb;

  // The last byte can only be taken when the queue has room.
  assign last_byte = (pos_r == chd_pkg::POS_LAST);
  assign in_ready  = !last_byte || !q_full;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept && last_byte;

  // Byte position counter.
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = last_byte ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Header store; the last byte carries nothing that is decoded.
  always_ff @(posedge clk) begin
    for (int i = 0; i < chd_pkg::HEADER_LENGTH - 1; i++) begin
      if (accept && (pos_r == chd_pkg::POS_BITS'(i))) begin
        hdr_r[i] <= in_data.header_byte;
      end
    end
  end

  // Signature and flag decoding.
  assign is_ines = (hdr_r[0] == chd_pkg::CH_N) && (hdr_r[1] == chd_pkg::CH_E) &&
                   (hdr_r[2] == chd_pkg::CH_S) && (hdr_r[3] == chd_pkg::CH_EOF);
  assign is_tnes = (hdr_r[0] == chd_pkg::CH_T) && (hdr_r[1] == chd_pkg::CH_N) &&
                   (hdr_r[2] == chd_pkg::CH_E) && (hdr_r[3] == chd_pkg::CH_S);
  assign nes2    = (hdr_r[7] & chd_pkg::NES2_MASK) == chd_pkg::NES2_VALUE;
  assign prg_msb = hdr_r[9][3:0];
  assign chr_msb = hdr_r[9][7:4];

  // Build the job record.
  always_comb begin
    q_wdata            = '0;
    q_wdata.image_size = in_data.image_size;
    if (is_ines) begin
      q_wdata.pre_status = chd_pkg::ST_OK;
      q_wdata.fmt        = nes2 ? chd_pkg::FMT_NES2 : chd_pkg::FMT_INES;
      q_wdata.mapper     = {nes2 ? hdr_r[8][3:0] : 4'h0, hdr_r[7][7:4], hdr_r[6][7:4]};
      q_wdata.prg_exp    = nes2 && (prg_msb == chd_pkg::EXP_FORM);
      q_wdata.chr_exp    = nes2 && (chr_msb == chd_pkg::EXP_FORM);
      q_wdata.prg_code   = {(nes2 && !q_wdata.prg_exp) ? prg_msb : 4'h0, hdr_r[4]};
      q_wdata.chr_code   = {(nes2 && !q_wdata.chr_exp) ? chr_msb : 4'h0, hdr_r[5]};
      q_wdata.prg_shift  = chd_pkg::PRG_UNIT_SHIFT;
      q_wdata.chr_shift  = chd_pkg::CHR_UNIT_SHIFT;
      q_wdata.trainer    = hdr_r[6][2];
    end else if (is_tnes) begin
      q_wdata.fmt = chd_pkg::FMT_TNES;
      if (hdr_r[4] == chd_pkg::TNES_FDS) begin
        q_wdata.pre_status = chd_pkg::ST_FDS;
      end else if (hdr_r[4] > chd_pkg::TNES_MAPPER_MAX) begin
        q_wdata.pre_status = chd_pkg::ST_MAPPER;
      end else begin
        q_wdata.pre_status = chd_pkg::ST_OK;
        q_wdata.mapper     = chd_pkg::tnes_mapper(hdr_r[4]);
        q_wdata.prg_code   = {4'h0, hdr_r[5]};
        q_wdata.chr_code   = {4'h0, hdr_r[6]};
        q_wdata.prg_shift  = chd_pkg::TNES_UNIT_SHIFT;
        q_wdata.chr_shift  = chd_pkg::TNES_UNIT_SHIFT;
      end
    end else begin
      q_wdata.pre_status = chd_pkg::ST_BAD_MAGIC;
      q_wdata.fmt        = chd_pkg::FMT_INES;
    end
  end

endmodule

@@ sv/chd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_queue: job queue between front and back
// A small first-in first-out buffer of classified headers.
// ----------------------------------------------------------------------------
module chd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  chd_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output chd_pkg::job_t rdata
);

  localparam int PTR_BITS = $clog2(chd_pkg::QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(chd_pkg::QUEUE_DEPTH + 1);

  chd_pkg::job_t         mem_r [chd_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full    = (count_r == CNT_BITS'(chd_pkg::QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(chd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(chd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ sv/chd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_back: size decoding and range checks
// Three stages: sizes and program offset, character offset with the program
// overrun check, then the character overrun check into the output register.
// ----------------------------------------------------------------------------
module chd_back #(
  parameter int SIZE_BITS = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  chd_pkg::job_t q_rdata,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output chd_pkg::out_t out_data
);

  localparam int SHW = 67;

  // Exponent-multiplier size, saturated to the size width.
  function automatic logic [SIZE_BITS-1:0] exp_size(input logic [7:0] b);
    logic [SHW-1:0] sh;
    logic           over;
    sh   = SHW'({b[1:0], 1'b1}) << b[7:2];
    over = ({1'b0, b[7:2]} >= 7'(SIZE_BITS)) || (|sh[SHW-1:SIZE_BITS]);
    return over ? '1 : sh[SIZE_BITS-1:0];
  endfunction

  // Size from either form; fixed forms always fit in the size width.
  function automatic logic [SIZE_BITS-1:0] field_size(input logic is_exp,
                                                      input logic [11:0] code,
                                                      input logic [3:0] shift);
    return is_exp ? exp_size(code[7:0]) : (SIZE_BITS'(code) << shift);
  endfunction

  logic en;

  // Stage 1 registers.
  logic                 v1_r;
  chd_pkg::status_t     pre1_r;
  chd_pkg::fmt_t        fmt1_r;
  logic [11:0]          map1_r;
  logic [SIZE_BITS-1:0] prg1_r, chr1_r;
  logic                 trn1_r;
  logic [9:0]           ps1_r;
  logic [31:0]          img1_r;

  // Stage 2 registers.
  logic                 v2_r;
  chd_pkg::status_t     pre2_r;
  chd_pkg::fmt_t        fmt2_r;
  logic [11:0]          map2_r;
  logic [SIZE_BITS-1:0] prg2_r, chr2_r;
  logic                 trn2_r;
  logic [9:0]           ps2_r;
  logic [31:0]          img2_r;
  logic [SIZE_BITS:0]   cs2_r;
  logic                 pzero2_r, pover2_r;

  // Output register.
  logic                 out_valid_r;
  chd_pkg::out_t        out_r, out_nxt;

  logic [SIZE_BITS:0]   cs_sum;
  logic [SIZE_BITS+1:0] chr_end;
  logic                 chr_over;

  // All stages advance together whenever the output register can move.
  assign en        = !out_valid_r || out_ready;
  assign q_pop     = en && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // Stage 1: decode both sizes and the program offset.
  always_ff @(posedge clk) begin
    if (en) begin
      pre1_r <= q_rdata.pre_status;
      fmt1_r <= q_rdata.fmt;
      map1_r <= q_rdata.mapper;
      prg1_r <= field_size(q_rdata.prg_exp, q_rdata.prg_code, q_rdata.prg_shift);
      chr1_r <= field_size(q_rdata.chr_exp, q_rdata.chr_code, q_rdata.chr_shift);
      trn1_r <= q_rdata.trainer;
      ps1_r  <= chd_pkg::HEADER_BYTES + (q_rdata.trainer ? chd_pkg::TRAINER_BYTES : 10'd0);
      img1_r <= q_rdata.image_size;
    end
  end

  // Stage 2: character offset and program checks.
  assign cs_sum = {1'b0, prg1_r} + (SIZE_BITS + 1)'(ps1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      pre2_r   <= pre1_r;
      fmt2_r   <= fmt1_r;
      map2_r   <= map1_r;
      prg2_r   <= prg1_r;
      chr2_r   <= chr1_r;
      trn2_r   <= trn1_r;
      ps2_r    <= ps1_r;
      img2_r   <= img1_r;
      cs2_r    <= cs_sum;
      pzero2_r <= (prg1_r == '0);
      pover2_r <= cs_sum > (SIZE_BITS + 1)'(img1_r);
    end
  end

  // Stage 3: character check, status priority and field zeroing.
  assign chr_end  = (SIZE_BITS + 2)'(cs2_r) + (SIZE_BITS + 2)'(chr2_r);
  assign chr_over = (chr2_r != '0) && (chr_end > (SIZE_BITS + 2)'(img2_r));

  always_comb begin
    out_nxt              = '0;
    out_nxt.image_format = fmt2_r;
    if (pre2_r != chd_pkg::ST_OK) begin
      out_nxt.status = pre2_r;
    end else begin
      if (pzero2_r) begin
        out_nxt.status = chd_pkg::ST_PRG_ZERO;
      end else if (pover2_r) begin
        out_nxt.status = chd_pkg::ST_PRG_OVER;
      end else if (chr_over) begin
        out_nxt.status = chd_pkg::ST_CHR_OVER;
      end else begin
        out_nxt.status = chd_pkg::ST_OK;
      end
      out_nxt.mapper_number = map2_r;
      out_nxt.prg_bytes     = 48'(prg2_r);
      out_nxt.chr_bytes     = 48'(chr2_r);
      out_nxt.trainer_bytes = trn2_r ? chd_pkg::TRAINER_BYTES : 10'd0;
      out_nxt.prg_start     = ps2_r;
      out_nxt.chr_start     = 49'(cs2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

endmodule

@@ sv/cartridge_header_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_header_decoder_top: iNES / NES 2.0 / TNES header decoder
// Takes sixteen header bytes and returns one decoded header record.
// ----------------------------------------------------------------------------
//  Channel  Ports              Direction  Carries
//  in       in_valid/in_ready  input      header byte and total image size
//  out      out_valid/out_ready output    status, format, mapper, sizes, offsets
//
//  One header byte is taken every cycle unless a last byte waits on a full
//  queue; a result follows each sixteenth byte. The job passes the job queue,
//  then the size stage, the offset stage and the output register.
//  Reset clears the byte position, the queue and all stage valid bits.
//  A stalled result holds the back stages; the front keeps taking bytes and
//  waits only on a last byte while the two-entry queue is full.
// ----------------------------------------------------------------------------
module cartridge_header_decoder_top #(
  parameter int SIZE_BITS = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  chd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output chd_pkg::out_t out_data
);

  logic          q_push, q_full, q_pop, q_valid;
  chd_pkg::job_t q_wdata, q_rdata;

  // Front: byte capture and classification.
  chd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  // Queue between the two halves.
  chd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // Back: sizes, checks and the output register.
  chd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("job pushed into a full queue");

  // A bad signature clears every decoded field.
  a_bad_magic_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == chd_pkg::ST_BAD_MAGIC)) |->
      (out_data.prg_bytes == '0 && out_data.chr_bytes == '0 &&
       out_data.mapper_number == '0 && out_data.chr_start == '0))
    else $error("bad signature result carries decoded fields");

  // A good result has a program block and a consistent character offset.
  a_ok_offsets: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == chd_pkg::ST_OK)) |->
      (out_data.prg_bytes != '0 &&
       out_data.chr_start == 49'(out_data.prg_start) + 49'(out_data.prg_bytes)))
    else $error("good result with inconsistent offsets");

  // For a good result, the program offset follows the trainer.
  a_prg_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == chd_pkg::ST_OK)) |->
      (out_data.prg_start == chd_pkg::HEADER_BYTES + out_data.trainer_bytes))
    else $error("program offset does not follow the trainer");

endmodule
